@@ rtl/core/bmp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the BMP 24-bit to RGB565 placer.
// ----------------------------------------------------------------------------
package bmp_pkg;

   localparam int MAX_IMAGE_WIDTH = 1280;
   localparam int SCREEN_MAX      = 1024;

   localparam int CSR_W    = 11;
   localparam int COORD_W  = 10;
   localparam int COLOR_W  = 16;
   localparam int COL_BITS = $clog2(MAX_IMAGE_WIDTH + 1);
   localparam int RB_BITS  = $clog2(MAX_IMAGE_WIDTH * 3 + 4);

   // header byte offsets
   localparam logic [5:0] HDR_DATA   = 6'd10;
   localparam logic [5:0] HDR_WIDTH  = 6'd18;
   localparam logic [5:0] HDR_HEIGHT = 6'd22;
   localparam logic [5:0] HDR_PLANES = 6'd26;
   localparam logic [5:0] HDR_BITS   = 6'd28;
   localparam logic [5:0] HDR_COMP   = 6'd30;
   localparam logic [5:0] HDR_END    = 6'd33;

   localparam logic [15:0] BITS_24 = 16'd24;

   // result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_EARLY  = 2'd3;

   // register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1);
   localparam int RSP_TDATA_W  = ((2 * COORD_W + COLOR_W + 7) / 8) * 8;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } bmp_result_type;

   // up to two results produced by one file byte
   typedef struct packed {
      logic [1:0]     count;
      bmp_result_type first;
      bmp_result_type second;
   } bmp_push_type;

endpackage

@@ rtl/core/bmp24_to_rgb565_placer.sv @@
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_placer
// Streams a 24-bit BMP file in and places its pixels as RGB565, centred where the image fits, clipped where not.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries the file one byte per beat, req_tlast on its final byte.
//   rsp_* carries results: tuser is the kind (pixel, header rejected, image
//   finished, file ended early), tlast marks the last result of a byte.
//   csr_* writes the screen width (index 0) and height (index 1); the values
//   are taken when a header is judged, so a write applies to the next file.
// Timing:
//   One byte per cycle while req_tready is high. A byte is held in the input
//   register, is decoded into the result queue the next cycle, and its first
//   result is valid once written there. A byte yields at most two results;
//   the queue (8 entries) drains one result a cycle while rsp_tready is high.
// Reset:
//   Synchronous; screen size returns to 128 x 128 and parsing to the header.
// Backpressure:
//   When rsp_tready stays low the queue fills and req_tready drops once fewer
//   than two free slots remain beyond what the byte in flight may need.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_placer import bmp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = file_byte[7:0]; tlast = byte_last
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   // response: tdata = pixel_x[9:0], pixel_y[19:10], pixel_color[35:20], zero fill
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // tuser = result_kind[1:0]
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_wen,
   input  logic                   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   logic                 beat;
   logic                 stage_busy;
   bmp_push_type         push;
   bmp_result_type       rsp_data;
   logic [RSP_CNT_W-1:0] count;

   // room for the byte in flight plus the one arriving now
   assign req_tready = (RSP_CNT_W'(count) + (stage_busy ? RSP_CNT_W'(2) : '0))
                       <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign beat       = req_tvalid && req_tready;

   bmp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat),
      .file_byte  (req_tdata),
      .byte_last  (req_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stage_busy (stage_busy),
      .push       (push)
   );

   bmp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (rsp_data),
      .count     (count)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_data.color, rsp_data.y, rsp_data.x});
   assign rsp_tuser = rsp_data.kind;
   assign rsp_tlast = rsp_data.last;

endmodule

@@ rtl/core/bmp_parser.sv @@
// ----------------------------------------------------------------------------
// bmp_parser
// Input register, header parse, geometry latch and pixel placement.
// ----------------------------------------------------------------------------
module bmp_parser import bmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             beat_valid,
   input  logic [7:0]       file_byte,
   input  logic             byte_last,
   input  logic             csr_wen,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output logic             stage_busy,
   output bmp_push_type     push
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_GAP    = 2'd1;
   localparam logic [1:0] PH_ROWS   = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;

   logic [CSR_W-1:0]    sw_ff, sh_ff;

   logic [1:0]          phase_ff, phase_in;
   logic [31:0]         pos_ff, pos_in;
   logic [31:0]         data_offset_ff, data_offset_in;
   logic [31:0]         width_ff, width_in;
   logic [31:0]         height_ff, height_in;
   logic [15:0]         planes_ff, planes_in;
   logic [15:0]         bits_ff, bits_in;
   logic [31:0]         comp_kind_ff, comp_kind_in;
   logic [RB_BITS-1:0]  idx_ff, idx_in;
   logic [1:0]          comp_ff, comp_in;
   logic [COL_BITS-1:0] px_ff, px_in;
   logic [31:0]         skip_ff, skip_in;
   logic [CSR_W-1:0]    to_draw_ff, to_draw_in;
   logic [COORD_W-1:0]  cur_row_ff, cur_row_in;
   logic [7:0]          blue_ff, blue_in;
   logic [7:0]          green_ff, green_in;
   logic [COORD_W-1:0]  x_start_ff, x_start_in;
   logic [COL_BITS-1:0] draw_cols_ff, draw_cols_in;
   logic [RB_BITS-1:0]  row_bytes_ff, row_bytes_in;

   // header judgment
   logic [31:0]         comp_full;
   logic                hdr_ok;
   logic [CSR_W-1:0]    sw_eff, sh_eff;
   logic                w_fit, h_fit;
   logic [CSR_W-1:0]    w11, h11, ys;
   logic [RB_BITS-1:0]  w_rb, rb_sum;
   logic [COORD_W-1:0]  j_x_start, j_top;
   logic [COL_BITS-1:0] j_draw_cols;
   logic [RB_BITS-1:0]  j_row_bytes;
   logic [31:0]         j_skip;
   logic [CSR_W-1:0]    j_draw;

   logic [5:0]          lo, rel;
   logic                pix_v, ev_v;
   logic [1:0]          ev_kind;
   bmp_result_type      pix_r, ev_r;

   assign stage_busy = in_valid_ff;

   assign comp_full = {in_byte_ff, comp_kind_ff[23:0]};
   assign sw_eff = (sw_ff == '0) ? CSR_W'(1) :
                   (sw_ff > CSR_W'(SCREEN_MAX)) ? CSR_W'(SCREEN_MAX) : sw_ff;
   assign sh_eff = (sh_ff == '0) ? CSR_W'(1) :
                   (sh_ff > CSR_W'(SCREEN_MAX)) ? CSR_W'(SCREEN_MAX) : sh_ff;

   assign hdr_ok = (planes_ff == 16'd1) && (bits_ff == BITS_24) && (comp_full == '0) &&
                   (width_ff != '0) && (width_ff <= 32'(MAX_IMAGE_WIDTH)) &&
                   (height_ff != '0) && !height_ff[31];

   assign w_fit = width_ff <= 32'(sw_eff);
   assign h_fit = height_ff <= 32'(sh_eff);
   assign w11   = width_ff[CSR_W-1:0];
   assign h11   = height_ff[CSR_W-1:0];

   assign j_x_start   = w_fit ? COORD_W'((sw_eff - w11) >> 1) : '0;
   assign j_draw_cols = w_fit ? COL_BITS'(width_ff) : COL_BITS'(sw_eff);

   assign w_rb        = RB_BITS'(width_ff);
   assign rb_sum      = (w_rb << 1) + w_rb + RB_BITS'(3);
   assign j_row_bytes = {rb_sum[RB_BITS-1:2], 2'b00};

   assign ys     = (sh_eff - h11) >> 1;
   assign j_skip = h_fit ? '0 : height_ff - 32'(sh_eff);
   assign j_draw = h_fit ? h11 : sh_eff;
   assign j_top  = h_fit ? COORD_W'(ys + h11 - CSR_W'(1)) : COORD_W'(sh_eff - CSR_W'(1));

   assign lo = pos_ff[5:0];

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      data_offset_in = data_offset_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      planes_in      = planes_ff;
      bits_in        = bits_ff;
      comp_kind_in   = comp_kind_ff;
      idx_in         = idx_ff;
      comp_in        = comp_ff;
      px_in          = px_ff;
      skip_in        = skip_ff;
      to_draw_in     = to_draw_ff;
      cur_row_in     = cur_row_ff;
      blue_in        = blue_ff;
      green_in       = green_ff;
      x_start_in     = x_start_ff;
      draw_cols_in   = draw_cols_ff;
      row_bytes_in   = row_bytes_ff;
      rel            = '0;
      pix_v          = 1'b0;
      ev_v           = 1'b0;
      ev_kind        = KIND_PIXEL;
      pix_r          = '0;

      if (in_valid_ff) begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + 32'd1;
         end

         case (phase_ff)
            PH_HEADER: begin
               // each header field is written one byte at a time, little endian
               if (pos_ff[31:6] == '0) begin
                  if (lo >= HDR_DATA && lo < HDR_DATA + 6'd4) begin
                     rel = lo - HDR_DATA;
                     data_offset_in[{rel[1:0], 3'b000} +: 8] = in_byte_ff;
                  end else if (lo >= HDR_WIDTH && lo < HDR_WIDTH + 6'd4) begin
                     rel = lo - HDR_WIDTH;
                     width_in[{rel[1:0], 3'b000} +: 8] = in_byte_ff;
                  end else if (lo >= HDR_HEIGHT && lo < HDR_HEIGHT + 6'd4) begin
                     rel = lo - HDR_HEIGHT;
                     height_in[{rel[1:0], 3'b000} +: 8] = in_byte_ff;
                  end else if (lo >= HDR_PLANES && lo < HDR_PLANES + 6'd2) begin
                     rel = lo - HDR_PLANES;
                     planes_in[{rel[0], 3'b000} +: 8] = in_byte_ff;
                  end else if (lo >= HDR_BITS && lo < HDR_BITS + 6'd2) begin
                     rel = lo - HDR_BITS;
                     bits_in[{rel[0], 3'b000} +: 8] = in_byte_ff;
                  end else if (lo >= HDR_COMP && lo < HDR_COMP + 6'd4) begin
                     rel = lo - HDR_COMP;
                     comp_kind_in[{rel[1:0], 3'b000} +: 8] = in_byte_ff;
                  end
                  if (lo == HDR_END) begin
                     if (hdr_ok) begin
                        phase_in     = PH_GAP;
                        x_start_in   = j_x_start;
                        draw_cols_in = j_draw_cols;
                        row_bytes_in = j_row_bytes;
                        skip_in      = j_skip;
                        to_draw_in   = j_draw;
                        cur_row_in   = j_top;
                        idx_in       = '0;
                        comp_in      = '0;
                        px_in        = '0;
                     end else begin
                        phase_in = PH_DONE;
                        ev_v     = 1'b1;
                        ev_kind  = KIND_REJECT;
                     end
                  end
               end
            end
            PH_GAP, PH_ROWS: begin
               if (phase_ff == PH_ROWS || pos_ff >= data_offset_ff) begin
                  phase_in = PH_ROWS;
                  if (skip_ff == '0 && px_ff < draw_cols_ff) begin
                     case (comp_ff)
                        2'd0: blue_in = in_byte_ff;
                        2'd1: green_in = in_byte_ff;
                        default: begin
                           pix_v       = 1'b1;
                           pix_r.kind  = KIND_PIXEL;
                           pix_r.x     = x_start_ff + COORD_W'(px_ff);
                           pix_r.y     = cur_row_ff;
                           pix_r.color = {in_byte_ff[7:3], green_ff[7:2], blue_ff[7:3]};
                           if (px_ff == draw_cols_ff - COL_BITS'(1)) begin
                              to_draw_in = to_draw_ff - CSR_W'(1);
                              if (to_draw_ff == CSR_W'(1)) begin
                                 phase_in = PH_DONE;
                                 ev_v     = 1'b1;
                                 ev_kind  = KIND_FINISH;
                              end else if (cur_row_ff != '0) begin
                                 cur_row_in = cur_row_ff - COORD_W'(1);
                              end
                           end
                        end
                     endcase
                  end
                  // row end, padding included
                  if (idx_ff >= row_bytes_ff - RB_BITS'(1)) begin
                     idx_in  = '0;
                     comp_in = '0;
                     px_in   = '0;
                     if (skip_ff != '0) begin
                        skip_in = skip_ff - 32'd1;
                     end
                  end else begin
                     idx_in = idx_ff + RB_BITS'(1);
                     if (comp_ff == 2'd2) begin
                        comp_in = '0;
                        px_in   = px_ff + COL_BITS'(1);
                     end else begin
                        comp_in = comp_ff + 2'd1;
                     end
                  end
               end
            end
            default: ;
         endcase

         if (in_last_ff) begin
            if (phase_in != PH_DONE) begin
               ev_v    = 1'b1;
               ev_kind = KIND_EARLY;
            end
            phase_in = PH_HEADER;
            pos_in   = '0;
            idx_in   = '0;
            comp_in  = '0;
            px_in    = '0;
         end
      end

      ev_r       = '0;
      ev_r.kind  = ev_kind;
      ev_r.last  = 1'b1;
      pix_r.last = !ev_v;

      push.count  = {1'b0, pix_v} + {1'b0, ev_v};
      push.first  = pix_v ? pix_r : ev_r;
      push.second = ev_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sw_ff       <= CSR_W'(128);
         sh_ff       <= CSR_W'(128);
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         idx_ff      <= '0;
         comp_ff     <= '0;
         px_ff       <= '0;
      end else begin
         in_valid_ff <= beat_valid;
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         comp_ff     <= comp_in;
         px_ff       <= px_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  sw_ff <= csr_wdata;
               CSR_SCREEN_HEIGHT: sh_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (beat_valid) begin
         in_byte_ff <= file_byte;
         in_last_ff <= byte_last;
      end
      data_offset_ff <= data_offset_in;
      width_ff       <= width_in;
      height_ff      <= height_in;
      planes_ff      <= planes_in;
      bits_ff        <= bits_in;
      comp_kind_ff   <= comp_kind_in;
      skip_ff        <= skip_in;
      to_draw_ff     <= to_draw_in;
      cur_row_ff     <= cur_row_in;
      blue_ff        <= blue_in;
      green_ff       <= green_in;
      x_start_ff     <= x_start_in;
      draw_cols_ff   <= draw_cols_in;
      row_bytes_ff   <= row_bytes_in;
   end

endmodule

@@ rtl/core/bmp_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// bmp_rsp_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle while pop_ready is high.
// ----------------------------------------------------------------------------
module bmp_rsp_fifo import bmp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  bmp_push_type         push,
   input  logic                 pop_ready,
   output logic                 pop_valid,
   output bmp_result_type       pop_data,
   output logic [RSP_CNT_W-1:0] count
);

   bmp_result_type       mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [RSP_PTR_W-1:0] wr_next;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign wr_next   = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

endmodule
